// File: design/text_mode_console_writer_macros.svh
// assertion macros for the text mode console writer
`ifndef TEXT_MODE_CONSOLE_WRITER_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS
`define TMCW_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define TMCW_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define TMCW_ASSERT(name, cond, msg)
`define TMCW_ASSERT_IMP(name, ante, cons, msg)
`endif

`endif

// File: design/tmcw_pkg.sv
// shared types and constants of the text mode console writer
package tmcw_pkg;

	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_SETPOS = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	localparam logic [7:0] COLOR_RESET = 8'h07;
	localparam logic [7:0] TAB_MASK    = ~8'd7;
	localparam logic [7:0] TAB_STEP    = 8'd8;

	typedef enum logic [2:0] {
		K_PRINT,
		K_NEWLINE,
		K_TAB,
		K_RETURN,
		K_BACKSP,
		K_SETPOS,
		K_CLEAR,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic [7:0] x;
		logic [7:0] y;
		logic       x_ok;
		logic       y_ok;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL,
		ST_DONE
	} state_t;

endpackage

// File: design/tmcw_ram.sv
// generic single write port ram with registered read
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/tmcw_front.sv
// front end: decodes a request into a command for the back end
module tmcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic [23:0]         req_data,
	input  logic [1:0]          req_op,
	output tmcw_pkg::cmd_t      cmd
);
	import tmcw_pkg::*;

	always_comb begin
		cmd.ch   = req_data[7:0];
		cmd.x    = req_data[15:8];
		cmd.y    = req_data[23:16];
		cmd.x_ok = (req_data[15:8] < 8'(COLUMNS));
		cmd.y_ok = (req_data[23:16] < 8'(ROWS));
		case (req_op)
			OP_PUT: begin
				case (req_data[7:0])
					CH_NEWLINE:   cmd.kind = K_NEWLINE;
					CH_TAB:       cmd.kind = K_TAB;
					CH_RETURN:    cmd.kind = K_RETURN;
					CH_BACKSPACE: cmd.kind = K_BACKSP;
					default:      cmd.kind = K_PRINT;
				endcase
			end
			OP_SETPOS: cmd.kind = K_SETPOS;
			OP_CLEAR:  cmd.kind = K_CLEAR;
			OP_READ:   cmd.kind = K_READ;
			default:   cmd.kind = K_READ;
		endcase
	end

endmodule

// File: design/tmcw_queue.sv
// two entry command queue between front and back end
module tmcw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tmcw_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output tmcw_pkg::cmd_t head
);
	import tmcw_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

endmodule

// File: design/tmcw_back.sv
// back end: cursor, screen buffer sweeps and result register
`include "text_mode_console_writer_macros.svh"

module tmcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [7:0]     cfg_data,
	input  logic           head_valid,
	input  tmcw_pkg::cmd_t head,
	output logic           pop,
	output logic           init_busy,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [31:0]    m_tdata,  // cursor_col, cursor_row, cell_char, cell_color
	output logic [0:0]     m_tuser   // cell_valid
);
	import tmcw_pkg::*;

	localparam int TOTAL  = COLUMNS * ROWS;
	localparam int COPY_N = COLUMNS * (ROWS - 1);
	localparam int LAST   = TOTAL - 1;
	localparam int AW     = $clog2(TOTAL);
	localparam int CW     = $clog2(COLUMNS);
	localparam int RW     = $clog2(ROWS);

	state_t          state_q, state_d;
	logic [AW-1:0]   cnt_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [7:0]      color_q;
	logic            pend_s1;
	logic [AW-1:0]   wadr_s1;
	logic [7:0]      res_char_q;
	logic [7:0]      res_color_q;
	logic            res_valid_q;
	logic            out_valid_q;
	logic [6:0]      out_col_q;
	logic [4:0]      out_row_q;
	logic [7:0]      out_char_q;
	logic [7:0]      out_color_q;
	logic            out_cv_q;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [15:0]     wdata;
	logic [AW-1:0]   raddr;
	logic [15:0]     rdata;
	logic [7:0]      nc;
	logic [6:0]      nr;
	logic            scroll;
	logic            out_free;
	logic            is_put;
	logic [AW:0]     scroll_rd;

	assign out_free  = !out_valid_q || m_tready;
	assign is_put    = (head.kind == K_PRINT) || (head.kind == K_NEWLINE) ||
		(head.kind == K_TAB) || (head.kind == K_RETURN) || (head.kind == K_BACKSP);
	assign scroll_rd = (AW+1)'(cnt_q) + (AW+1)'(COLUMNS);

	// cursor movement of a put
	always_comb begin
		nc     = 8'(col_q);
		nr     = 7'(row_q);
		scroll = 1'b0;
		case (head.kind)
			K_NEWLINE: begin
				nc = 8'd0;
				nr = 7'(row_q) + 7'd1;
			end
			K_TAB:     nc = (8'(col_q) + TAB_STEP) & TAB_MASK;
			K_RETURN:  nc = 8'd0;
			K_BACKSP:  nc = (col_q == '0) ? 8'd0 : 8'(col_q) - 8'd1;
			K_PRINT:   nc = 8'(col_q) + 8'd1;
			default:   nc = 8'(col_q);
		endcase
		if (nc >= 8'(COLUMNS)) begin
			nc = 8'd0;
			nr = nr + 7'd1;
		end
		if (nr >= 7'(ROWS)) begin
			nr     = 7'(ROWS - 1);
			scroll = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (cnt_q == AW'(LAST)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head_valid) begin
					case (head.kind)
						K_SETPOS: state_d = ST_DONE;
						K_CLEAR:  state_d = ST_FILL;
						K_READ:   state_d = (head.x_ok && head.y_ok) ? ST_READ : ST_DONE;
						default:  state_d = scroll ? ST_SCROLL : ST_DONE;
					endcase
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_SCROLL: begin
				if (cnt_q == AW'(COPY_N)) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (cnt_q == AW'(LAST)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// buffer ports and queue pop
	always_comb begin
		pop   = (state_q == ST_IDLE) && head_valid;
		we    = 1'b0;
		waddr = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
		wdata = {color_q, head.ch};
		raddr = AW'(head.y) * AW'(COLUMNS) + AW'(head.x);
		if (state_q == ST_SCROLL) begin
			raddr = scroll_rd[AW-1:0];
		end
		if (pend_s1) begin
			we    = 1'b1;
			waddr = wadr_s1;
			wdata = rdata;
		end else if ((state_q == ST_INIT) || (state_q == ST_FILL)) begin
			we    = 1'b1;
			waddr = cnt_q;
			wdata = {(state_q == ST_INIT) ? COLOR_RESET : color_q, CH_SPACE};
		end else if (pop && (head.kind == K_PRINT)) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			color_q     <= COLOR_RESET;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == ST_SCROLL) && (cnt_q < AW'(COPY_N));
			if (cfg_valid) begin
				color_q <= cfg_data;
			end
			case (state_q)
				ST_INIT: cnt_q <= (cnt_q == AW'(LAST)) ? '0 : cnt_q + AW'(1);
				ST_IDLE: begin
					cnt_q <= '0;
					if (head_valid) begin
						if (is_put) begin
							col_q <= nc[CW-1:0];
							row_q <= nr[RW-1:0];
						end else if (head.kind == K_SETPOS) begin
							if (head.x_ok) begin
								col_q <= head.x[CW-1:0];
							end
							if (head.y_ok) begin
								row_q <= head.y[RW-1:0];
							end
						end else if (head.kind == K_CLEAR) begin
							col_q <= '0;
							row_q <= '0;
						end
					end
				end
				ST_SCROLL: begin
					if (cnt_q != AW'(COPY_N)) begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_FILL: cnt_q <= cnt_q + AW'(1);
				default: cnt_q <= cnt_q;
			endcase
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wadr_s1 <= cnt_q;
		if (pop) begin
			res_char_q  <= 8'd0;
			res_color_q <= 8'd0;
			res_valid_q <= 1'b0;
		end else if (state_q == ST_READ) begin
			res_char_q  <= rdata[7:0];
			res_color_q <= rdata[15:8];
			res_valid_q <= 1'b1;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_col_q   <= 7'(col_q);
			out_row_q   <= 5'(row_q);
			out_char_q  <= res_char_q;
			out_color_q <= res_color_q;
			out_cv_q    <= res_valid_q;
		end
	end

	tmcw_ram #(
		.WIDTH(16),
		.DEPTH(TOTAL)
	) u_screen (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign cfg_ready = 1'b1;
	assign init_busy = (state_q == ST_INIT);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {4'd0, out_color_q, out_char_q, out_row_q, out_col_q};
	assign m_tuser   = out_cv_q;

	`TMCW_ASSERT(a_col_range, 32'(col_q) < COLUMNS, "cursor column out of range")
	`TMCW_ASSERT(a_row_range, 32'(row_q) < ROWS, "cursor row out of range")
	`TMCW_ASSERT_IMP(a_copy_in_scroll, pend_s1, state_q == ST_SCROLL, "copy write outside scroll")
	`TMCW_ASSERT_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "result without completion")

endmodule

// File: design/text_mode_console_writer.sv
// top level of the text mode console writer
// Character-cell console with a COLUMNS x ROWS screen buffer in a single RAM and a
// cursor. Requests enter a two entry queue and are executed one at a time; each
// request gives one result. A printable character, a control code without
// scroll, a set position or an out-of-screen read goes straight from idle to
// done in the back end, a cell read passes through a read state. A scroll is
// a copy through the RAM's one write port, one cell a cycle, then a fill of
// the last row; a clear is a fill of every cell. After reset a clearing pass
// fills the screen with spaces in color 0x07; s_tready stays low during it
// while text_color writes are taken at any time.
module text_mode_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,    // text_color
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,     // char_code, pos_x, pos_y
	input  logic [1:0]  s_tuser,     // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // cursor_col, cursor_row, cell_char, cell_color
	output logic [0:0]  m_tuser      // cell_valid
);
	import tmcw_pkg::*;

	cmd_t cmd;
	cmd_t head;
	logic q_full;
	logic head_valid;
	logic pop;
	logic init_busy;
	logic push;

	assign s_tready = !q_full && !init_busy;
	assign push     = s_tvalid && s_tready;

	tmcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.req_data(s_tdata),
		.req_op  (s_tuser),
		.cmd     (cmd)
	);

	tmcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (cmd),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	tmcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.init_busy (init_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
